FILE: rtl/dtt_pkg.sv
package dtt_pkg;

  // Operation codes carried by in_kind.
  localparam logic [2:0] K_ADD     = 3'd0;
  localparam logic [2:0] K_CANCEL  = 3'd1;
  localparam logic [2:0] K_REFRESH = 3'd2;
  localparam logic [2:0] K_RESET   = 3'd3;
  localparam logic [2:0] K_SCAN    = 3'd4;
  localparam logic [2:0] K_WAIT    = 3'd5;

  // Result status codes.
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_EXPIRED = 2'd3;

  // Most entries expired by one scan, and the register reset value.
  localparam int          MAX_RESULTS    = 16;
  localparam logic [31:0] DEFAULT_WINDOW = 32'd3600000;

  // Register write port of the period and deadline memories.
  typedef struct packed {
    logic per_we;
    logic dl_we;
  } dtt_wr_t;

  // Sequencer states.
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_OP    = 7'b0000010,
    S_SET   = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_WALK  = 7'b0010000,
    S_FLUSH = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

endpackage

FILE: rtl/deadline_timer_table.sv
// Channel  | Direction | Handshake            | Payload
// in_      | in        | in_valid / in_stall  | kind, handle, period_ms, recurring, rebase_now, now_ms
// out_     | out       | out_valid / out_stall| status, slot_out, wait_ms, front_notice, last
// APB      | in        | psel/penable/pready  | rollover_window, paddr not decoded
//
// The slot walk reads one slot a cycle through the memory read port. Add, wait and a reset
// that changes its slot each make one walk; cancel, refresh and a refused or unchanged reset
// make none. A scan of a non-empty table with k expiries makes k + 1 walks (k walks when
// MAX_RESULTS stops it) and emits one result per expiry, or a done result if k is 0; at the
// limit, the flush state emits the last result.
// One item is worked on at a time; in_stall is high until the sequencer is back in idle.
// Reset is synchronous and active low; the memories need no clearing pass.
// A stalled output holds its result and the sequencer waits before giving the next.
module deadline_timer_table #(
  parameter int TIMER_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [3:0]  in_handle,
  input  logic [63:0] in_period_ms,
  input  logic        in_recurring,
  input  logic        in_rebase_now,
  input  logic [63:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [3:0]  out_slot_out,
  output logic [63:0] out_wait_ms,
  output logic        out_front_notice,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dtt_pkg::*;

  localparam int IW = $clog2(TIMER_SLOTS);
  localparam int CW = $clog2(TIMER_SLOTS + 1);
  localparam int RW = $clog2(MAX_RESULTS + 1);

  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [IW-1:0] slot_r, slot_nxt;
  logic [63:0] per_r, per_nxt, now_r, now_nxt, start_r, start_nxt;
  logic        fnow_r, fnow_nxt;
  logic [TIMER_SLOTS-1:0] active_r, active_nxt, rep_r, rep_nxt, picked_r, picked_nxt;
  logic [63:0] prev_now_r, prev_now_nxt;
  logic        notice_r, notice_nxt;
  logic [31:0] window_r;
  logic        roll_r, roll_nxt;
  logic [CW-1:0] wcnt_r, wcnt_nxt;
  logic        rv_r, rv_nxt, found_r, found_nxt;
  logic [IW-1:0] ri_r, ri_nxt, best_i_r, best_i_nxt, prv_r, prv_nxt;
  logic [63:0] best_d_r, best_d_nxt, best_p_r, best_p_nxt;
  logic [RW-1:0] cnt_r, cnt_nxt;
  logic        hp_r, hp_nxt;
  logic [1:0]  res_status_r, res_status_nxt;
  logic [IW-1:0] res_slot_r, res_slot_nxt;
  logic [63:0] res_wait_r, res_wait_nxt;
  logic        res_front_r, res_front_nxt, res_last_r, res_last_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic [3:0]  out_slot_r, out_slot_nxt;
  logic [63:0] out_wait_r, out_wait_nxt;
  logic        out_front_r, out_front_nxt, out_last_r, out_last_nxt;

  dtt_wr_t     wr;
  logic [IW-1:0] waddr, raddr;
  logic [63:0] wper, wdl, rd_per, rd_dl;

  logic [IW+3:0] hx;
  logic [IW-1:0] hs, free_idx;
  logic        valid_h, free_any, elig, fc, walk_done;
  logic [IW+3:0] sx;
  logic [RW-1:0] cnt_inc;

  dtt_store #(.SLOTS(TIMER_SLOTS)) u_store (
    .clk   (clk),
    .wr    (wr),
    .waddr (waddr),
    .wper  (wper),
    .wdl   (wdl),
    .raddr (raddr),
    .rper  (rd_per),
    .rdl   (rd_dl)
  );

  // Handle decode and lowest free slot search.
  always_comb begin
    hx = {{IW{1'b0}}, in_handle};
    valid_h = ({28'd0, in_handle} < 32'(TIMER_SLOTS));
    hs = valid_h ? hx[IW-1:0] : '0;
    free_any = ~&active_r;
    free_idx = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= DEFAULT_WINDOW;
    end else if (psel && penable && pwrite) begin
      window_r <= pwdata;
    end
  end

  assign prdata = window_r;
  assign pready = 1'b1;

  // Sequencer: operations, the slot walk and result emission.
  always_comb begin
    state_nxt = state_r;
    ret_nxt = ret_r;
    kind_nxt = kind_r;
    slot_nxt = slot_r;
    per_nxt = per_r;
    now_nxt = now_r;
    fnow_nxt = fnow_r;
    start_nxt = start_r;
    active_nxt = active_r;
    rep_nxt = rep_r;
    picked_nxt = picked_r;
    prev_now_nxt = prev_now_r;
    notice_nxt = notice_r;
    roll_nxt = roll_r;
    wcnt_nxt = wcnt_r;
    rv_nxt = 1'b0;
    ri_nxt = ri_r;
    found_nxt = found_r;
    best_i_nxt = best_i_r;
    best_d_nxt = best_d_r;
    best_p_nxt = best_p_r;
    cnt_nxt = cnt_r;
    hp_nxt = hp_r;
    prv_nxt = prv_r;
    res_status_nxt = res_status_r;
    res_slot_nxt = res_slot_r;
    res_wait_nxt = res_wait_r;
    res_front_nxt = res_front_r;
    res_last_nxt = res_last_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_slot_nxt = out_slot_r;
    out_wait_nxt = out_wait_r;
    out_front_nxt = out_front_r;
    out_last_nxt = out_last_r;
    wr = '0;
    waddr = slot_r;
    wper = per_r;
    wdl = '0;
    raddr = wcnt_r[IW-1:0];
    elig = 1'b0;
    fc = 1'b0;
    walk_done = 1'b0;
    sx = '0;
    cnt_inc = cnt_r + RW'(1);

    case (state_r)
      S_IDLE: begin
        raddr = hs;
        if (in_valid) begin
          kind_nxt = in_kind;
          slot_nxt = hs;
          per_nxt = in_period_ms;
          now_nxt = in_now_ms;
          fnow_nxt = in_rebase_now;
          ret_nxt = S_IDLE;
          res_status_nxt = ST_DONE;
          res_slot_nxt = '0;
          res_wait_nxt = '0;
          res_front_nxt = 1'b0;
          res_last_nxt = 1'b1;
          wcnt_nxt = '0;
          found_nxt = 1'b0;
          state_nxt = S_EMIT;
          case (in_kind)
            K_ADD: begin
              if (!free_any) begin
                res_status_nxt = ST_FULL;
              end else begin
                wr.per_we = 1'b1;
                wr.dl_we = 1'b1;
                waddr = free_idx;
                wper = in_period_ms;
                wdl = in_now_ms + in_period_ms;
                active_nxt[free_idx] = 1'b1;
                rep_nxt[free_idx] = in_recurring;
                slot_nxt = free_idx;
                state_nxt = S_WALK;
              end
            end
            K_CANCEL: begin
              if (!valid_h || !active_r[hs]) begin
                res_status_nxt = ST_REFUSED;
              end else begin
                active_nxt[hs] = 1'b0;
              end
            end
            K_REFRESH: begin
              if (!valid_h || !active_r[hs]) begin
                res_status_nxt = ST_REFUSED;
              end else begin
                state_nxt = S_OP;
              end
            end
            K_RESET: begin
              if (!valid_h) begin
                res_status_nxt = ST_REFUSED;
              end else begin
                state_nxt = S_OP;
              end
            end
            K_SCAN: begin
              state_nxt = S_SCAN;
            end
            K_WAIT: begin
              notice_nxt = 1'b0;
              state_nxt = S_WALK;
            end
            default: begin
              state_nxt = S_EMIT;
            end
          endcase
        end
      end

      // Stored period and deadline of the handle are on the read port.
      S_OP: begin
        state_nxt = S_EMIT;
        if (kind_r == K_REFRESH) begin
          wr.dl_we = 1'b1;
          wdl = now_r + rd_per;
        end else if (per_r == rd_per && !fnow_r) begin
          res_status_nxt = ST_DONE;
        end else if (!active_r[slot_r]) begin
          res_status_nxt = ST_REFUSED;
        end else begin
          start_nxt = fnow_r ? now_r : rd_dl - rd_per;
          state_nxt = S_SET;
        end
      end

      S_SET: begin
        wr.per_we = 1'b1;
        wr.dl_we = 1'b1;
        wdl = start_r + per_r;
        state_nxt = S_WALK;
      end

      // Scan setup: empty table check and clock rollover test.
      S_SCAN: begin
        if (!(|active_r)) begin
          state_nxt = S_EMIT;
        end else begin
          roll_nxt = (now_r < prev_now_r) &&
                     ((prev_now_r - now_r) > {32'd0, window_r});
          prev_now_nxt = now_r;
          cnt_nxt = '0;
          hp_nxt = 1'b0;
          picked_nxt = '0;
          state_nxt = S_WALK;
        end
      end

      // One slot read per cycle; the compare runs in the cycle after the read.
      S_WALK: begin
        if (wcnt_r < CW'(TIMER_SLOTS)) begin
          wcnt_nxt = wcnt_r + CW'(1);
          rv_nxt = 1'b1;
          ri_nxt = wcnt_r[IW-1:0];
        end
        if (rv_r) begin
          elig = active_r[ri_r] && (kind_r != K_SCAN ||
                 (!picked_r[ri_r] && (roll_r || rd_dl <= now_r)));
          if (elig && (!found_r || rd_dl < best_d_r)) begin
            found_nxt = 1'b1;
            best_i_nxt = ri_r;
            best_d_nxt = rd_dl;
            best_p_nxt = rd_per;
          end
        end
        walk_done = (wcnt_r == CW'(TIMER_SLOTS)) && !rv_r;
        if (walk_done) begin
          ret_nxt = S_IDLE;
          res_status_nxt = ST_DONE;
          res_slot_nxt = '0;
          res_wait_nxt = '0;
          res_front_nxt = 1'b0;
          res_last_nxt = 1'b1;
          state_nxt = S_EMIT;
          case (kind_r)
            K_ADD, K_RESET: begin
              fc = (best_i_r == slot_r) && !notice_r;
              notice_nxt = notice_r | fc;
              res_front_nxt = fc;
              if (kind_r == K_ADD) begin
                res_slot_nxt = slot_r;
              end
            end
            K_WAIT: begin
              if (!found_r) begin
                res_wait_nxt = '1;
              end else if (now_r >= best_d_r) begin
                res_wait_nxt = '0;
              end else begin
                res_wait_nxt = best_d_r - now_r;
              end
            end
            default: begin
              if (found_r) begin
                // Expire the pick now; it is excluded from later walks.
                picked_nxt[best_i_r] = 1'b1;
                if (rep_r[best_i_r]) begin
                  wr.dl_we = 1'b1;
                  waddr = best_i_r;
                  wdl = now_r + best_p_r;
                end else begin
                  active_nxt[best_i_r] = 1'b0;
                end
                cnt_nxt = cnt_inc;
                prv_nxt = best_i_r;
                hp_nxt = 1'b1;
                wcnt_nxt = '0;
                found_nxt = 1'b0;
                ret_nxt = (cnt_inc == RW'(MAX_RESULTS)) ? S_FLUSH : S_WALK;
                if (hp_r) begin
                  res_status_nxt = ST_EXPIRED;
                  res_slot_nxt = prv_r;
                  res_last_nxt = 1'b0;
                end else begin
                  state_nxt = ret_nxt;
                end
              end else if (hp_r) begin
                res_status_nxt = ST_EXPIRED;
                res_slot_nxt = prv_r;
              end
            end
          endcase
        end
      end

      S_FLUSH: begin
        res_status_nxt = ST_EXPIRED;
        res_slot_nxt = prv_r;
        res_wait_nxt = '0;
        res_front_nxt = 1'b0;
        res_last_nxt = 1'b1;
        ret_nxt = S_IDLE;
        state_nxt = S_EMIT;
      end

      // Hand the pending result to the output register once it is free.
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          sx = {4'd0, res_slot_r};
          out_valid_nxt = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt = sx[3:0];
          out_wait_nxt = res_wait_r;
          out_front_nxt = res_front_r;
          out_last_nxt = res_last_r;
          state_nxt = ret_r;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r <= S_IDLE;
      active_r <= '0;
      rep_r <= '0;
      prev_now_r <= '0;
      notice_r <= 1'b0;
      rv_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
      active_r <= active_nxt;
      rep_r <= rep_nxt;
      prev_now_r <= prev_now_nxt;
      notice_r <= notice_nxt;
      rv_r <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    slot_r <= slot_nxt;
    per_r <= per_nxt;
    now_r <= now_nxt;
    fnow_r <= fnow_nxt;
    start_r <= start_nxt;
    picked_r <= picked_nxt;
    roll_r <= roll_nxt;
    wcnt_r <= wcnt_nxt;
    ri_r <= ri_nxt;
    found_r <= found_nxt;
    best_i_r <= best_i_nxt;
    best_d_r <= best_d_nxt;
    best_p_r <= best_p_nxt;
    cnt_r <= cnt_nxt;
    hp_r <= hp_nxt;
    prv_r <= prv_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r <= res_slot_nxt;
    res_wait_r <= res_wait_nxt;
    res_front_r <= res_front_nxt;
    res_last_r <= res_last_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r <= out_slot_nxt;
    out_wait_r <= out_wait_nxt;
    out_front_r <= out_front_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot_out = out_slot_r;
  assign out_wait_ms = out_wait_r;
  assign out_front_notice = out_front_r;
  assign out_last = out_last_r;

  // The best candidate of a walk is always a live entry.
  a_best_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && found_r) |-> active_r[best_i_r])
    else $error("walk candidate is not active");

  // A scan never starts another walk after its last allowed expiry.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && kind_r == K_SCAN) |-> (cnt_r < RW'(MAX_RESULTS)))
    else $error("scan walked past the result limit");

  // The front notice is raised only by the end of an add or reset walk.
  a_notice_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(notice_r) |-> $past(state_r == S_WALK && (kind_r == K_ADD || kind_r == K_RESET)))
    else $error("front notice raised outside an add or reset");

endmodule

FILE: rtl/dtt_store.sv
module dtt_store #(
  parameter int SLOTS = 16
) (
  input  logic                       clk,
  input  dtt_pkg::dtt_wr_t           wr,
  input  logic [$clog2(SLOTS)-1:0]   waddr,
  input  logic [63:0]                wper,
  input  logic [63:0]                wdl,
  input  logic [$clog2(SLOTS)-1:0]   raddr,
  output logic [63:0]                rper,
  output logic [63:0]                rdl
);
  import dtt_pkg::*;

  logic [63:0] per_mem [SLOTS];
  logic [63:0] dl_mem  [SLOTS];

  // Period memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr.per_we) begin
      per_mem[waddr] <= wper;
    end
    rper <= per_mem[raddr];
  end

  // Deadline memory, addressed alongside the period memory.
  always_ff @(posedge clk) begin
    if (wr.dl_we) begin
      dl_mem[waddr] <= wdl;
    end
    rdl <= dl_mem[raddr];
  end

endmodule

FILE: test/deadline_timer_table_tb.sv
`timescale 1ns / 100ps

module deadline_timer_table_tb;
  import dtt_pkg::*;

  localparam int SLOTS = 16;
  localparam int IDLE_WAIT = 400;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [2:0] K_UNUSED6 = 3'd6;
  localparam logic [2:0] K_UNUSED7 = 3'd7;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [63:0] wait_ms;
    logic        front;
    logic        last;
  } timer_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_kind = '0;
  logic [3:0]  in_handle = '0;
  logic [63:0] in_period_ms = '0;
  logic        in_recurring = 1'b0;
  logic        in_rebase_now = 1'b0;
  logic [63:0] in_now_ms = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [3:0]  out_slot_out;
  logic [63:0] out_wait_ms;
  logic        out_front_notice;
  logic        out_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow copy of the timer table.
  logic        sh_active [SLOTS];
  logic        sh_repeat [SLOTS];
  logic        sh_written [SLOTS];
  logic [63:0] sh_period [SLOTS];
  logic [63:0] sh_deadline [SLOTS];
  logic [63:0] sh_prev_now;
  logic        sh_pending;
  logic [31:0] sh_window;

  timer_result_t pending_results[$];
  int mismatches = 0;
  int quiet_cycles = 0;
  bit stall_free = 1'b0;
  logic [63:0] clock_ms = 64'd1000;

  always #2 clk = ~clk;

  deadline_timer_table dut (.*);

  // Slot a orders before slot b by deadline, then by slot number.
  function automatic bit orders_first(int a, int b);
    if (sh_deadline[a] != sh_deadline[b]) return sh_deadline[a] < sh_deadline[b];
    return a < b;
  endfunction

  function automatic int earliest_slot();
    int best;
    best = -1;
    for (int i = 0; i < SLOTS; i++)
      if (sh_active[i] && (best < 0 || orders_first(i, best))) best = i;
    return best;
  endfunction

  function automatic logic front_check(int s);
    if (earliest_slot() == s && !sh_pending) begin
      sh_pending = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void push_result(logic [1:0] st, logic [3:0] slot, logic [63:0] w,
                                      logic front, logic last);
    timer_result_t r;
    r.status = st;
    r.slot = slot;
    r.wait_ms = w;
    r.front = front;
    r.last = last;
    pending_results.insert(pending_results.size(), r);
  endfunction

  // Work out the results of one accepted item and update the shadow table.
  function automatic void predict_timer_op(logic [2:0] kind, logic [3:0] h, logic [63:0] per,
                                           logic rec, logic fnow, logic [63:0] now);
    int s;
    int n;
    int best;
    int picked_list[MAX_RESULTS];
    bit picked[SLOTS];
    bit roll;
    logic [63:0] start;
    s = -1;
    n = 0;
    case (kind)
      K_ADD: begin
        for (int i = 0; i < SLOTS; i++)
          if (!sh_active[i] && s < 0) s = i;
        if (s < 0) push_result(ST_FULL, 4'd0, '0, 1'b0, 1'b1);
        else begin
          sh_active[s] = 1'b1;
          sh_repeat[s] = rec;
          sh_written[s] = 1'b1;
          sh_period[s] = per;
          sh_deadline[s] = now + per;
          push_result(ST_DONE, s[3:0], '0, front_check(s), 1'b1);
        end
      end
      K_CANCEL: begin
        if (!sh_active[h]) push_result(ST_REFUSED, 4'd0, '0, 1'b0, 1'b1);
        else begin
          sh_active[h] = 1'b0;
          push_result(ST_DONE, 4'd0, '0, 1'b0, 1'b1);
        end
      end
      K_REFRESH: begin
        if (!sh_active[h]) push_result(ST_REFUSED, 4'd0, '0, 1'b0, 1'b1);
        else begin
          sh_deadline[h] = now + sh_period[h];
          push_result(ST_DONE, 4'd0, '0, 1'b0, 1'b1);
        end
      end
      K_RESET: begin
        if (per == sh_period[h] && !fnow) push_result(ST_DONE, 4'd0, '0, 1'b0, 1'b1);
        else if (!sh_active[h]) push_result(ST_REFUSED, 4'd0, '0, 1'b0, 1'b1);
        else begin
          start = fnow ? now : sh_deadline[h] - sh_period[h];
          sh_period[h] = per;
          sh_deadline[h] = start + per;
          push_result(ST_DONE, 4'd0, '0, front_check(h), 1'b1);
        end
      end
      K_SCAN: begin
        if (earliest_slot() < 0) push_result(ST_DONE, 4'd0, '0, 1'b0, 1'b1);
        else begin
          roll = (now < sh_prev_now) && ((sh_prev_now - now) > {32'd0, sh_window});
          sh_prev_now = now;
          for (int i = 0; i < SLOTS; i++) picked[i] = 1'b0;
          best = 0;
          while (n < MAX_RESULTS && best >= 0) begin
            best = -1;
            for (int i = 0; i < SLOTS; i++)
              if (sh_active[i] && !picked[i] && (roll || sh_deadline[i] <= now) &&
                  (best < 0 || orders_first(i, best)))
                best = i;
            if (best >= 0) begin
              picked[best] = 1'b1;
              picked_list[n] = best;
              n++;
            end
          end
          if (n == 0) push_result(ST_DONE, 4'd0, '0, 1'b0, 1'b1);
          for (int k = 0; k < n; k++) begin
            s = picked_list[k];
            if (sh_repeat[s]) sh_deadline[s] = now + sh_period[s];
            else sh_active[s] = 1'b0;
            push_result(ST_EXPIRED, s[3:0], '0, 1'b0, k == n - 1);
          end
        end
      end
      K_WAIT: begin
        sh_pending = 1'b0;
        s = earliest_slot();
        if (s < 0) push_result(ST_DONE, 4'd0, ALL_ONES, 1'b0, 1'b1);
        else if (now >= sh_deadline[s]) push_result(ST_DONE, 4'd0, '0, 1'b0, 1'b1);
        else push_result(ST_DONE, 4'd0, sh_deadline[s] - now, 1'b0, 1'b1);
      end
      default: push_result(ST_DONE, 4'd0, '0, 1'b0, 1'b1);
    endcase
  endfunction

  // Offer one item, wait for its acceptance, then leave a random gap.
  task automatic send_timer_op(logic [2:0] kind, logic [3:0] h, logic [63:0] per,
                               logic rec, logic fnow, logic [63:0] now);
    int r;
    int gap;
    in_valid <= 1'b1;
    in_kind <= kind;
    in_handle <= h;
    in_period_ms <= per;
    in_recurring <= rec;
    in_rebase_now <= fnow;
    in_now_ms <= now;
    do @(posedge clk); while (in_stall);
    predict_timer_op(kind, h, per, rec, fnow, now);
    r = $urandom_range(0, 99);
    if (r < 60) gap = 0;
    else if (r < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 50);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every expected result has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic write_window(logic [31:0] value);
    drain_results();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 2'd0;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sh_window = value;
    @(posedge clk);
  endtask

  // Directed operations at the extremes of each field.
  task automatic test_directed_ops();
    send_timer_op(K_WAIT, 4'd0, '0, 1'b0, 1'b0, clock_ms);
    send_timer_op(K_SCAN, 4'd0, '0, 1'b0, 1'b0, clock_ms);
    send_timer_op(K_CANCEL, 4'd15, '0, 1'b0, 1'b0, clock_ms);
    send_timer_op(K_REFRESH, 4'd3, '0, 1'b0, 1'b0, clock_ms);
    send_timer_op(K_ADD, 4'd0, 64'd50, 1'b1, 1'b0, clock_ms);
    send_timer_op(K_ADD, 4'd0, 64'd10, 1'b0, 1'b0, clock_ms);
    send_timer_op(K_WAIT, 4'd0, '0, 1'b0, 1'b0, clock_ms);
    send_timer_op(K_ADD, 4'd0, 64'd0, 1'b0, 1'b0, clock_ms);
    send_timer_op(K_ADD, 4'd0, ALL_ONES, 1'b1, 1'b0, clock_ms);
    send_timer_op(K_RESET, 4'd0, 64'd50, 1'b0, 1'b0, clock_ms);
    send_timer_op(K_RESET, 4'd0, 64'd5, 1'b0, 1'b1, clock_ms);
    send_timer_op(K_RESET, 4'd1, 64'd70, 1'b0, 1'b0, clock_ms);
    send_timer_op(K_REFRESH, 4'd1, '0, 1'b0, 1'b0, clock_ms);
    send_timer_op(K_CANCEL, 4'd1, '0, 1'b0, 1'b0, clock_ms);
    // Reset of a freed slot with a new period is refused.
    send_timer_op(K_RESET, 4'd1, 64'd9, 1'b1, 1'b0, clock_ms);
    send_timer_op(K_UNUSED6, 4'd0, '0, 1'b0, 1'b0, clock_ms);
    send_timer_op(K_UNUSED7, 4'hF, ALL_ONES, 1'b1, 1'b1, ALL_ONES);
    clock_ms = clock_ms + 64'd20;
    send_timer_op(K_SCAN, 4'd0, '0, 1'b0, 1'b0, clock_ms);
    // Fill the table past its end.
    for (int i = 0; i < 17; i++)
      send_timer_op(K_ADD, 4'd0, 64'(i % 3), 1'b0, 1'b0, clock_ms);
    send_timer_op(K_SCAN, 4'd0, '0, 1'b0, 1'b0, clock_ms + 64'd5);
  endtask

  // A backward jump larger than the window expires everything.
  task automatic test_rollover(logic [31:0] window);
    write_window(window);
    clock_ms = 64'h0000_0001_0000_0000;
    send_timer_op(K_ADD, 4'd0, 64'd1000, 1'b0, 1'b0, clock_ms);
    send_timer_op(K_SCAN, 4'd0, '0, 1'b0, 1'b0, clock_ms);
    send_timer_op(K_SCAN, 4'd0, '0, 1'b0, 1'b0, clock_ms - {32'd0, window});
    send_timer_op(K_ADD, 4'd0, 64'd1000, 1'b1, 1'b0, clock_ms);
    send_timer_op(K_SCAN, 4'd0, '0, 1'b0, 1'b0, clock_ms - {32'd0, window} - 64'd1);
    clock_ms = clock_ms - {32'd0, window} - 64'd1;
  endtask

  // Random operations with time mostly moving forward.
  task automatic test_random_ops(int count);
    int r;
    int h;
    logic [2:0] kind;
    logic [63:0] per;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) drain_results();
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 3) clock_ms = {$urandom, $urandom};
      else clock_ms = clock_ms + 64'($urandom_range(0, 20));
      if ($urandom_range(0, 19) == 0) per = {$urandom, $urandom};
      else per = 64'($urandom_range(0, 60));
      h = $urandom_range(0, SLOTS - 1);
      if (r < 25) kind = K_ADD;
      else if (r < 35) kind = K_CANCEL;
      else if (r < 45) kind = K_REFRESH;
      else if (r < 60) kind = K_RESET;
      else if (r < 85) kind = K_SCAN;
      else if (r < 97) kind = K_WAIT;
      else kind = $urandom_range(0, 1) ? K_UNUSED6 : K_UNUSED7;
      if (kind == K_RESET) begin
        // Only slots that hold a period may be reset.
        for (int i = 0; i < SLOTS && !sh_written[h]; i++) h = (h + 1) % SLOTS;
        if (!sh_written[h]) kind = K_ADD;
        else if ($urandom_range(0, 3) == 0) per = sh_period[h];
      end
      send_timer_op(kind, 4'(h), per, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    clock_ms);
    end
  endtask

  // Result checker and receiver stall generator.
  always @(posedge clk) begin
    timer_result_t got;
    timer_result_t want;
    int r;
    int stall_left;
    if (rst_n && out_valid && !out_stall) begin
      got.status = out_status;
      got.slot = out_slot_out;
      got.wait_ms = out_wait_ms;
      got.front = out_front_notice;
      got.last = out_last;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
    if (stall_free) out_stall <= 1'b0;
    else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) out_stall <= 1'b0;
      else begin
        stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        out_stall <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      sh_active[i] = 1'b0;
      sh_repeat[i] = 1'b0;
      sh_written[i] = 1'b0;
      sh_period[i] = '0;
      sh_deadline[i] = '0;
    end
    sh_prev_now = '0;
    sh_pending = 1'b0;
    sh_window = DEFAULT_WINDOW;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    stall_free = 1'b1;
    test_directed_ops();
    stall_free = 1'b0;
    test_rollover(32'd0);
    test_rollover(32'hFFFF_FFFF);
    write_window(DEFAULT_WINDOW);
    test_random_ops(150);
    write_window(32'd0);
    test_random_ops(150);
    write_window($urandom);
    test_random_ops(114);
    drain_results();
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
